// ===== src/rmac_pkg.sv =====
// ----------------------------------------------------------------------------
// rmac_pkg
// Shared constants, types and the arctangent table of the rotation matrix
// attitude converter.
// ----------------------------------------------------------------------------
package rmac_pkg;

  // cordic micro-rotations per atan2, capped by the table length
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int CSTEPS       = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

  // datapath widths
  localparam int CW = 36;   // cordic x/y, 2^14 scaled
  localparam int ZW = 32;   // cordic angle, 2^-28 rad
  localparam logic signed [ZW-1:0] PI_Z = 32'sd843314857;

  // quotient bits and dividend width of the quaternion divider
  localparam int QBITS  = 22;
  localparam int DIV_NW = 28;

  // square root iterations, one result bit each
  localparam int SQ_STAGES = 16;

  // register stages of each lane unit
  localparam int CORD_LAT = CSTEPS + 2;
  localparam int DIV_LAT  = QBITS + 2;
  localparam int LANE_LAT = (CORD_LAT > DIV_LAT) ? CORD_LAT : DIV_LAT;

  // mode codes
  localparam logic [1:0] MODE_PYR  = 2'd0;
  localparam logic [1:0] MODE_PKO  = 2'd1;
  localparam logic [1:0] MODE_QUAT = 2'd2;

  // matrix and side data travelling down the front of the pipe
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m13;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic signed [15:0] m23;
    logic signed [15:0] m31;
    logic signed [15:0] m32;
    logic signed [15:0] m33;
    logic signed [15:0] s;
    logic               bad;
  } rmac_side_t;

  // what rides alongside the lane units
  typedef struct packed {
    logic        vld;
    logic [1:0]  mode;
    logic        bad;
    logic [15:0] w;
  } rmac_tail_t;

  // atan(2^-i) in units of 2^-28 rad
  function automatic logic signed [ZW-1:0] atan_val(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:       v = 32'sd210828714;
      1:       v = 32'sd124459457;
      2:       v = 32'sd65760959;
      3:       v = 32'sd33381290;
      4:       v = 32'sd16755422;
      5:       v = 32'sd8385879;
      6:       v = 32'sd4193963;
      7:       v = 32'sd2097109;
      8:       v = 32'sd1048571;
      9:       v = 32'sd524287;
      10:      v = 32'sd262144;
      11:      v = 32'sd131072;
      12:      v = 32'sd65536;
      13:      v = 32'sd32768;
      14:      v = 32'sd16384;
      15:      v = 32'sd8192;
      16:      v = 32'sd4096;
      17:      v = 32'sd2048;
      18:      v = 32'sd1024;
      19:      v = 32'sd512;
      20:      v = 32'sd256;
      21:      v = 32'sd128;
      22:      v = 32'sd64;
      23:      v = 32'sd32;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/rmac_if.sv =====
// ----------------------------------------------------------------------------
// rmac_if
// Valid/ready channels of the attitude converter: matrix in, result out.
// ----------------------------------------------------------------------------
interface rmac_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [15:0] m11;
  logic signed [15:0] m12;
  logic signed [15:0] m13;
  logic signed [15:0] m21;
  logic signed [15:0] m22;
  logic signed [15:0] m23;
  logic signed [15:0] m31;
  logic signed [15:0] m32;
  logic signed [15:0] m33;

  modport source (output valid, mode, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                  input ready);
  modport sink (input valid, mode, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                output ready);
endinterface

interface rmac_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] first_value;
  logic signed [15:0] second_value;
  logic signed [15:0] third_value;
  logic signed [15:0] fourth_value;
  logic               invalid;

  modport source (output valid, first_value, second_value, third_value, fourth_value,
                  invalid, input ready);
  modport sink (input valid, first_value, second_value, third_value, fourth_value,
                invalid, output ready);
endinterface

// ===== src/rmac_cordic.sv =====
// ----------------------------------------------------------------------------
// rmac_cordic
// Pipelined vectoring cordic atan2, one micro-rotation per stage, Q2.13 out.
// ----------------------------------------------------------------------------
module rmac_cordic import rmac_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [16:0] y_i,
  input  logic signed [16:0] x_i,
  input  logic               zero_i,
  output logic signed [15:0] angle_o
);

  logic signed [CW-1:0] x_r    [CSTEPS+1];
  logic signed [CW-1:0] y_r    [CSTEPS+1];
  logic signed [ZW-1:0] z_r    [CSTEPS+1];
  logic                 zero_r [CSTEPS+1];
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] x_nxt;
  logic signed [CW-1:0] y_nxt;
  logic signed [ZW-1:0] z_nxt;
  logic signed [ZW:0]   zsum;
  logic signed [17:0]   zsh;
  logic signed [15:0]   angle_nxt;
  logic signed [15:0]   angle_r;

  // scale up and fold the left half plane onto the right
  always_comb begin
    xs = $signed({{(CW-31){x_i[16]}}, x_i, 14'b0});
    ys = $signed({{(CW-31){y_i[16]}}, y_i, 14'b0});
    if (xs < 0) begin
      x_nxt = -xs;
      y_nxt = -ys;
      z_nxt = (ys >= 0) ? PI_Z : -PI_Z;
    end else begin
      x_nxt = xs;
      y_nxt = ys;
      z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x_nxt;
      y_r[0]    <= y_nxt;
      z_r[0]    <= z_nxt;
      zero_r[0] <= zero_i;
    end
  end

  // micro-rotation stages
  for (genvar i = 0; i < CSTEPS; i++) begin : g_step
    logic signed [CW-1:0] xsh;
    logic signed [CW-1:0] ysh;
    assign xsh = x_r[i] >>> i;
    assign ysh = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + ysh;
          y_r[i+1] <= y_r[i] - xsh;
          z_r[i+1] <= z_r[i] + atan_val(i);
        end else begin
          x_r[i+1] <= x_r[i] - ysh;
          y_r[i+1] <= y_r[i] + xsh;
          z_r[i+1] <= z_r[i] - atan_val(i);
        end
      end
    end
  end

  // round to Q2.13 and saturate
  always_comb begin
    zsum = $signed({z_r[CSTEPS][ZW-1], z_r[CSTEPS]}) + 33'sd16384;
    zsh  = zsum[ZW:15];
    if (zero_r[CSTEPS]) begin
      angle_nxt = '0;
    end else if (zsh > 18'sd32767) begin
      angle_nxt = 16'sh7fff;
    end else if (zsh < -18'sd32768) begin
      angle_nxt = 16'sh8000;
    end else begin
      angle_nxt = zsh[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

  assign angle_o = angle_r;

endmodule

// ===== src/rmac_div.sv =====
// ----------------------------------------------------------------------------
// rmac_div
// Pipelined restoring divider: (num * 4096) / den, truncated, saturated.
// ----------------------------------------------------------------------------
module rmac_div import rmac_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [17:0] num_i,
  input  logic [15:0]        den_i,
  output logic signed [15:0] quo_o
);

  logic [DIV_NW-1:0] rem_r [QBITS+1];
  logic [QBITS-1:0]  q_r   [QBITS+1];
  logic [15:0]       den_r [QBITS+1];
  logic              neg_r [QBITS+1];
  logic signed [17:0] mag;
  logic signed [QBITS:0] qs;
  logic signed [15:0] quo_nxt;
  logic signed [15:0] quo_r;

  // magnitude of the dividend before scaling
  assign mag = num_i[17] ? -num_i : num_i;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {mag[15:0], 12'b0};
      q_r[0]   <= '0;
      den_r[0] <= den_i;
      neg_r[0] <= num_i[17];
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < QBITS; j++) begin : g_bit
    localparam int B = QBITS - 1 - j;
    logic [DIV_NW+QBITS-1:0] dsh;
    logic [DIV_NW+QBITS-1:0] remx;
    assign dsh  = (DIV_NW+QBITS)'(den_r[j]) << B;
    assign remx = (DIV_NW+QBITS)'(rem_r[j]);
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[j+1] <= den_r[j];
        neg_r[j+1] <= neg_r[j];
        if (remx >= dsh) begin
          rem_r[j+1] <= DIV_NW'(remx - dsh);
          q_r[j+1]   <= q_r[j] | (QBITS'(1) << B);
        end else begin
          rem_r[j+1] <= rem_r[j];
          q_r[j+1]   <= q_r[j];
        end
      end
    end
  end

  // apply sign and saturate
  always_comb begin
    qs = neg_r[QBITS] ? -$signed({1'b0, q_r[QBITS]}) : $signed({1'b0, q_r[QBITS]});
    if (qs > (QBITS+1)'(32767)) begin
      quo_nxt = 16'sh7fff;
    end else if (qs < -(QBITS+1)'(32768)) begin
      quo_nxt = 16'sh8000;
    end else begin
      quo_nxt = qs[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo_o = quo_r;

endmodule

// ===== src/rotation_matrix_attitude_convert.sv =====
// Throughput: one item per cycle while not stalled; the 24-stage divider sets
// the lane depth and the cordic is padded to match, the 16-stage square root
// sets the front end. The whole pipe stalls together while a result waits at
// the output. Reset clears all valid bits and the side data in the tail;
// other payload registers are not reset.
// ----------------------------------------------------------------------------
// rotation_matrix_attitude_convert
// Rotation matrix to ZYX angles, photogrammetric angles or quaternion.
// ----------------------------------------------------------------------------
module rotation_matrix_attitude_convert import rmac_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rmac_in_if.sink    in_if,
  rmac_out_if.source out_if
);

  localparam int PAD_C = LANE_LAT - CORD_LAT;
  localparam int PAD_D = LANE_LAT - DIV_LAT;

  logic               en;
  logic               out_valid_r;

  logic               v0_r;
  rmac_side_t         s0_r;
  logic               v1_r;
  rmac_side_t         s1_r;
  rmac_side_t         s1_nxt;
  logic [30:0]        p11_r;
  logic [30:0]        p21_r;
  logic [28:0]        pss_r;
  logic [16:0]        t_r;
  logic signed [31:0] p11_full;
  logic signed [31:0] p21_full;
  logic signed [31:0] pss_full;
  logic signed [16:0] ns;
  logic signed [18:0] t_full;
  logic [31:0]        rad_nxt;

  logic               vq_r    [SQ_STAGES+1];
  rmac_side_t         sq_side_r [SQ_STAGES+1];
  logic [31:0]        n_r     [SQ_STAGES+1];
  logic [17:0]        rem_r   [SQ_STAGES+1];
  logic [15:0]        root_r  [SQ_STAGES+1];

  rmac_side_t         sf;
  logic [15:0]        root_f;
  logic               gimbal;
  logic signed [16:0] ya, xa, yb, xb, yc, xc;
  logic               za, zb, zc;
  logic signed [17:0] nx, ny, nz;
  logic signed [15:0] ang_a, ang_b, ang_c;
  logic signed [15:0] qx, qy, qz;
  logic signed [15:0] ang_a_d, ang_b_d, ang_c_d;
  logic signed [15:0] qx_d, qy_d, qz_d;
  rmac_tail_t         tail_r [LANE_LAT];
  rmac_tail_t         tl;

  logic signed [15:0] first_nxt, second_nxt, third_nxt, fourth_nxt;
  logic               invalid_nxt;
  logic signed [15:0] first_r, second_r, third_r, fourth_r;
  logic               invalid_r;

  // the whole pipe moves unless a result is held at the output
  assign en          = !out_valid_r || out_if.ready;
  assign in_if.ready = en;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r.mode <= in_if.mode;
      s0_r.m11  <= in_if.m11;
      s0_r.m12  <= in_if.m12;
      s0_r.m13  <= in_if.m13;
      s0_r.m21  <= in_if.m21;
      s0_r.m22  <= in_if.m22;
      s0_r.m23  <= in_if.m23;
      s0_r.m31  <= in_if.m31;
      s0_r.m32  <= in_if.m32;
      s0_r.m33  <= in_if.m33;
      s0_r.s    <= '0;
      s0_r.bad  <= 1'b0;
    end
  end

  // squares, clamped sine and trace term
  always_comb begin
    ns       = -$signed({s0_r.m23[15], s0_r.m23});
    s1_nxt   = s0_r;
    if (ns > 17'sd16384) begin
      s1_nxt.s = 16'sd16384;
    end else if (ns < -17'sd16384) begin
      s1_nxt.s = -16'sd16384;
    end else begin
      s1_nxt.s = ns[15:0];
    end
    t_full     = 19'sd16384 + 19'(s0_r.m11) + 19'(s0_r.m22) + 19'(s0_r.m33);
    s1_nxt.bad = (t_full <= 19'sd0);
    p11_full   = s0_r.m11 * s0_r.m11;
    p21_full   = s0_r.m21 * s0_r.m21;
    pss_full   = s1_nxt.s * s1_nxt.s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r  <= s1_nxt;
      p11_r <= p11_full[30:0];
      p21_r <= p21_full[30:0];
      pss_r <= pss_full[28:0];
      t_r   <= t_full[16:0];
    end
  end

  // radicand for the shared square root
  always_comb begin
    case (s1_r.mode)
      MODE_PYR:  rad_nxt = {1'b0, p11_r} + {1'b0, p21_r};
      MODE_PKO:  rad_nxt = 32'd268435456 - {3'b0, pss_r};
      MODE_QUAT: rad_nxt = s1_r.bad ? 32'd0 : {3'b0, t_r, 12'b0};
      default:   rad_nxt = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r[0] <= 1'b0;
    end else if (en) begin
      vq_r[0] <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side_r[0] <= s1_r;
      n_r[0]       <= rad_nxt;
      rem_r[0]     <= '0;
      root_r[0]    <= '0;
    end
  end

  // digit-by-digit square root, one root bit per stage
  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    logic [19:0] remx;
    logic [19:0] trial;
    assign remx  = {rem_r[k], n_r[k][31:30]};
    assign trial = {2'b0, root_r[k], 2'b01};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vq_r[k+1] <= 1'b0;
      end else if (en) begin
        vq_r[k+1] <= vq_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_side_r[k+1] <= sq_side_r[k];
        n_r[k+1]       <= {n_r[k][29:0], 2'b00};
        if (remx >= trial) begin
          rem_r[k+1]  <= 18'(remx - trial);
          root_r[k+1] <= {root_r[k][14:0], 1'b1};
        end else begin
          rem_r[k+1]  <= remx[17:0];
          root_r[k+1] <= {root_r[k][14:0], 1'b0};
        end
      end
    end
  end

  assign sf     = sq_side_r[SQ_STAGES];
  assign root_f = root_r[SQ_STAGES];

  // lane operands per mode
  always_comb begin
    gimbal = (sf.mode == MODE_PKO) && (root_f == 16'd0);
    xa     = $signed({1'b0, root_f});
    if (sf.mode == MODE_PKO) begin
      ya = $signed({sf.s[15], sf.s});
      yb = $signed({sf.m13[15], sf.m13});
      xb = $signed({sf.m33[15], sf.m33});
      yc = $signed({sf.m21[15], sf.m21});
      xc = $signed({sf.m22[15], sf.m22});
    end else begin
      ya = -$signed({sf.m31[15], sf.m31});
      yb = $signed({sf.m21[15], sf.m21});
      xb = $signed({sf.m11[15], sf.m11});
      yc = $signed({sf.m32[15], sf.m32});
      xc = $signed({sf.m33[15], sf.m33});
    end
    za = (ya == 17'sd0) && (xa == 17'sd0);
    zb = ((yb == 17'sd0) && (xb == 17'sd0)) || gimbal;
    zc = ((yc == 17'sd0) && (xc == 17'sd0)) || gimbal;
    nx = 18'(sf.m32) - 18'(sf.m23);
    ny = 18'(sf.m13) - 18'(sf.m31);
    nz = 18'(sf.m21) - 18'(sf.m12);
  end

  rmac_cordic u_cordic_a (.clk(clk), .en(en), .y_i(ya), .x_i(xa), .zero_i(za),
                          .angle_o(ang_a));
  rmac_cordic u_cordic_b (.clk(clk), .en(en), .y_i(yb), .x_i(xb), .zero_i(zb),
                          .angle_o(ang_b));
  rmac_cordic u_cordic_c (.clk(clk), .en(en), .y_i(yc), .x_i(xc), .zero_i(zc),
                          .angle_o(ang_c));

  rmac_div u_div_x (.clk(clk), .en(en), .num_i(nx), .den_i(root_f), .quo_o(qx));
  rmac_div u_div_y (.clk(clk), .en(en), .num_i(ny), .den_i(root_f), .quo_o(qy));
  rmac_div u_div_z (.clk(clk), .en(en), .num_i(nz), .den_i(root_f), .quo_o(qz));

  // side data and valid alongside the lane units
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        tail_r[i] <= '0;
      end
    end else if (en) begin
      tail_r[0] <= '{vld: vq_r[SQ_STAGES], mode: sf.mode, bad: sf.bad, w: root_f};
      for (int i = 1; i < LANE_LAT; i++) begin
        tail_r[i] <= tail_r[i-1];
      end
    end
  end

  assign tl = tail_r[LANE_LAT-1];

  // align the shorter lane unit
  if (PAD_C > 0) begin : g_pad_c
    logic [47:0] pc_r [PAD_C];
    always_ff @(posedge clk) begin
      if (en) begin
        pc_r[0] <= {ang_a, ang_b, ang_c};
        for (int i = 1; i < PAD_C; i++) begin
          pc_r[i] <= pc_r[i-1];
        end
      end
    end
    assign {ang_a_d, ang_b_d, ang_c_d} = pc_r[PAD_C-1];
  end else begin : g_nopad_c
    assign {ang_a_d, ang_b_d, ang_c_d} = {ang_a, ang_b, ang_c};
  end

  if (PAD_D > 0) begin : g_pad_d
    logic [47:0] pd_r [PAD_D];
    always_ff @(posedge clk) begin
      if (en) begin
        pd_r[0] <= {qx, qy, qz};
        for (int i = 1; i < PAD_D; i++) begin
          pd_r[i] <= pd_r[i-1];
        end
      end
    end
    assign {qx_d, qy_d, qz_d} = pd_r[PAD_D-1];
  end else begin : g_nopad_d
    assign {qx_d, qy_d, qz_d} = {qx, qy, qz};
  end

  // result select per mode
  always_comb begin
    first_nxt   = '0;
    second_nxt  = '0;
    third_nxt   = '0;
    fourth_nxt  = '0;
    invalid_nxt = 1'b0;
    case (tl.mode)
      MODE_PYR: begin
        first_nxt  = ang_a_d;
        second_nxt = ang_b_d;
        third_nxt  = ang_c_d;
      end
      MODE_PKO: begin
        first_nxt  = ang_b_d;
        second_nxt = ang_c_d;
        third_nxt  = ang_a_d;
      end
      MODE_QUAT: begin
        if (tl.bad) begin
          invalid_nxt = 1'b1;
        end else begin
          first_nxt  = qx_d;
          second_nxt = qy_d;
          third_nxt  = qz_d;
          fourth_nxt = $signed(tl.w);
        end
      end
      default: begin
        invalid_nxt = 1'b0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= tl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      first_r   <= first_nxt;
      second_r  <= second_nxt;
      third_r   <= third_nxt;
      fourth_r  <= fourth_nxt;
      invalid_r <= invalid_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.first_value  = first_r;
  assign out_if.second_value = second_r;
  assign out_if.third_value  = third_r;
  assign out_if.fourth_value = fourth_r;
  assign out_if.invalid      = invalid_r;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives random and corner-case rotation matrices into the attitude converter
// in all modes, predicts each result with a bit-exact model of its
// fixed-point arithmetic, and compares results in order under random stalls.
// ----------------------------------------------------------------------------
module tb_top import rmac_pkg::*; ();

  typedef struct {
    logic [1:0]  mode;
    logic [15:0] m [9];
  } matrix_item_t;

  typedef struct {
    logic [15:0] v [4];
    logic        invalid;
  } attitude_t;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   in_idle_pct;
  int   out_idle_pct;

  rmac_in_if  in_if ();
  rmac_out_if out_if ();

  rotation_matrix_attitude_convert dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mismatch report
  task automatic report_mismatch(input string what);
    $display("tb_top: mismatch %s", what);
    mismatches++;
  endtask

  // floor integer square root
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [15:0] clip16(input longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // vectoring cordic arctangent, Q2.13 radians
  function automatic logic [15:0] arctan2(input longint yin, input longint xin);
    longint xv, yv, zv, xs, ys;
    if (yin == 0 && xin == 0) return 16'd0;
    xv = xin * 16384;
    yv = yin * 16384;
    zv = 0;
    if (xv < 0) begin
      zv = (yv >= 0) ? longint'(PI_Z) : -longint'(PI_Z);
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < CSTEPS; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv >= 0) begin
        xv = xv + ys;
        yv = yv - xs;
        zv += longint'(atan_val(i));
      end else begin
        xv = xv - ys;
        yv = yv + xs;
        zv -= longint'(atan_val(i));
      end
    end
    return clip16((zv + 16384) >>> 15);
  endfunction

  // expected converter output for one matrix
  function automatic attitude_t convert_matrix(input matrix_item_t it);
    attitude_t r;
    longint e [9];
    longint s, c, t, w;
    for (int k = 0; k < 4; k++) r.v[k] = 16'd0;
    r.invalid = 1'b0;
    for (int k = 0; k < 9; k++) e[k] = longint'($signed(it.m[k]));
    case (it.mode)
      MODE_PYR: begin
        c = longint'(int_sqrt(e[0] * e[0] + e[3] * e[3]));
        r.v[0] = arctan2(-e[6], c);
        r.v[1] = arctan2(e[3], e[0]);
        r.v[2] = arctan2(e[7], e[8]);
      end
      MODE_PKO: begin
        s = -e[5];
        if (s > 16384) s = 16384;
        if (s < -16384) s = -16384;
        c = longint'(int_sqrt((64'd1 << 28) - s * s));
        r.v[2] = arctan2(s, c);
        if (c != 0) begin
          r.v[0] = arctan2(e[2], e[8]);
          r.v[1] = arctan2(e[3], e[4]);
        end
      end
      MODE_QUAT: begin
        t = 16384 + e[0] + e[4] + e[8];
        if (t <= 0) begin
          r.invalid = 1'b1;
        end else begin
          w = longint'(int_sqrt(t * 4096));
          r.v[0] = clip16((e[7] - e[5]) * 4096 / w);
          r.v[1] = clip16((e[2] - e[6]) * 4096 / w);
          r.v[2] = clip16((e[3] - e[1]) * 4096 / w);
          r.v[3] = clip16(w);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // in-order store of expected attitudes
  class attitude_board;
    attitude_t pending[$];

    function void note_matrix(matrix_item_t it);
      pending = {pending, convert_matrix(it)};
    endfunction

    task check_result(attitude_t got);
      attitude_t exp_r;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing pending");
        return;
      end
      exp_r = pending.pop_front();
      for (int k = 0; k < 4; k++)
        if (got.v[k] !== exp_r.v[k])
          report_mismatch($sformatf("field %0d got %h exp %h", k, got.v[k], exp_r.v[k]));
      if (got.invalid !== exp_r.invalid)
        report_mismatch($sformatf("invalid got %b exp %b", got.invalid, exp_r.invalid));
    endtask
  endclass

  attitude_board board = new();

  // result side: random stall, check on accept
  always @(posedge clk) begin
    attitude_t got;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.v[0] = out_if.first_value;
        got.v[1] = out_if.second_value;
        got.v[2] = out_if.third_value;
        got.v[3] = out_if.fourth_value;
        got.invalid = out_if.invalid;
        board.check_result(got);
      end
      out_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // send one matrix, with random idle cycles before it
  task automatic send_matrix(input matrix_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= it.mode;
    in_if.m11 <= it.m[0]; in_if.m12 <= it.m[1]; in_if.m13 <= it.m[2];
    in_if.m21 <= it.m[3]; in_if.m22 <= it.m[4]; in_if.m23 <= it.m[5];
    in_if.m31 <= it.m[6]; in_if.m32 <= it.m[7]; in_if.m33 <= it.m[8];
    do @(posedge clk); while (!in_if.ready);
    board.note_matrix(it);
  endtask

  function automatic logic [15:0] pick_entry(input int style);
    case (style)
      0: return 16'($urandom);
      1: return 16'($urandom_range(32768) - 16384);
      2: return 16'($urandom_range(8) - 4);
      default: begin
        case ($urandom_range(4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h4000;
          3: return 16'hc000;
          default: return 16'h0000;
        endcase
      end
    endcase
  endfunction

  // random matrix; rotation-like entries for styles 0 to 3, picked entries otherwise
  function automatic matrix_item_t random_matrix();
    matrix_item_t it;
    int style;
    real a, b, g;
    real rm [9];
    it.mode = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
    style = $urandom_range(9);
    if (style < 4) begin
      a = ($urandom_range(62831) / 10000.0) - 3.14159;
      b = ($urandom_range(31415) / 10000.0) - 1.5708;
      g = ($urandom_range(62831) / 10000.0) - 3.14159;
      rm[0] = $cos(a) * $cos(b);
      rm[1] = $cos(a) * $sin(b) * $sin(g) - $sin(a) * $cos(g);
      rm[2] = $cos(a) * $sin(b) * $cos(g) + $sin(a) * $sin(g);
      rm[3] = $sin(a) * $cos(b);
      rm[4] = $sin(a) * $sin(b) * $sin(g) + $cos(a) * $cos(g);
      rm[5] = $sin(a) * $sin(b) * $cos(g) - $cos(a) * $sin(g);
      rm[6] = -$sin(b);
      rm[7] = $cos(b) * $sin(g);
      rm[8] = $cos(b) * $cos(g);
      for (int k = 0; k < 9; k++)
        it.m[k] = 16'($rtoi(rm[k] * 16383.0) + int'($urandom_range(6)) - 3);
    end else begin
      for (int k = 0; k < 9; k++) it.m[k] = pick_entry(style - 4);
    end
    return it;
  endfunction

  function automatic matrix_item_t fill_matrix(input logic [1:0] md, input logic [15:0] val);
    matrix_item_t it;
    it.mode = md;
    for (int k = 0; k < 9; k++) it.m[k] = val;
    return it;
  endfunction

  // directed corners
  task automatic run_directed();
    matrix_item_t it;
    for (int md = 0; md < 4; md++) begin
      it = fill_matrix(2'(md), 16'h0000);
      it.m[0] = 16'h4000; it.m[4] = 16'h4000; it.m[8] = 16'h4000;
      send_matrix(it);
      send_matrix(fill_matrix(2'(md), 16'h8000));
      send_matrix(fill_matrix(2'(md), 16'h7fff));
      send_matrix(fill_matrix(2'(md), 16'h0000));
    end
    // negative x axis and gimbal lock / asin clamp
    it = fill_matrix(MODE_PYR, 16'h0000);
    it.m[0] = 16'hc000; it.m[8] = 16'hc000;
    send_matrix(it);
    it = fill_matrix(MODE_PKO, 16'h1000);
    it.m[5] = 16'hc000;
    send_matrix(it);
    it.m[5] = 16'h8000;
    send_matrix(it);
    it.m[5] = 16'h7fff;
    send_matrix(it);
    // trace term exactly zero and just positive
    it = fill_matrix(MODE_QUAT, 16'h0123);
    it.m[0] = 16'hc000; it.m[4] = 16'h0000; it.m[8] = 16'h0000;
    send_matrix(it);
    it.m[8] = 16'h0001;
    send_matrix(it);
    it = fill_matrix(MODE_QUAT, 16'h7fff);
    it.m[0] = 16'hc001; it.m[4] = 16'h0000; it.m[8] = 16'h0000;
    it.m[5] = 16'h8000; it.m[6] = 16'h8000; it.m[1] = 16'h8000;
    send_matrix(it);
  endtask

  // main sequence
  initial begin
    rst_n        = 1'b0;
    mismatches   = 0;
    in_idle_pct  = 38;
    out_idle_pct = 54;
    in_if.valid  = 1'b0;
    in_if.mode   = '0;
    in_if.m11 = '0; in_if.m12 = '0; in_if.m13 = '0;
    in_if.m21 = '0; in_if.m22 = '0; in_if.m23 = '0;
    in_if.m31 = '0; in_if.m32 = '0; in_if.m33 = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct  = (phase == 0) ? 38 : (phase == 1) ? 54 : 0;
      out_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 38 : 0;
      for (int n = 0; n < 450; n++) send_matrix(random_matrix());
    end
    in_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
